FILE: src/rpn_pkg.sv
package rpn_pkg;

	localparam int unsigned XLEN = 32;

	typedef enum logic [2:0] {
		KIND_PUSH    = 3'd0,
		KIND_ADD     = 3'd1,
		KIND_SUB     = 3'd2,
		KIND_MUL     = 3'd3,
		KIND_DIV     = 3'd4,
		KIND_INVALID = 3'd5,
		KIND_END     = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_FEW      = 3'd1,
		STAT_DIVZERO  = 3'd2,
		STAT_INVALID  = 3'd3,
		STAT_DEPTH    = 3'd4,
		STAT_OVERFLOW = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage

FILE: src/rpn_ram.sv
module rpn_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/rpn_div.sv
module rpn_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [rpn_pkg::XLEN-1:0]       num,
	input  logic [rpn_pkg::XLEN-1:0]       den,
	output logic                           done,
	output logic [rpn_pkg::XLEN-1:0]       quot
);
	import rpn_pkg::*;

	localparam int unsigned CW = $clog2(XLEN);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic            neg_q;
	logic [XLEN-1:0] rem_q;
	logic [XLEN-1:0] q_q;
	logic [XLEN-1:0] dmag_q;
	logic [XLEN:0]   trial;

	// restoring step: shift in next dividend bit, try subtracting divisor
	assign trial = {rem_q, q_q[XLEN-1]} - {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(XLEN - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= num[XLEN-1] ^ den[XLEN-1];
			q_q    <= num[XLEN-1] ? (XLEN'(0) - num) : num;
			dmag_q <= den[XLEN-1] ? (XLEN'(0) - den) : den;
			rem_q  <= '0;
		end else if (busy_q) begin
			if (trial[XLEN]) begin
				rem_q <= {rem_q[XLEN-2:0], q_q[XLEN-1]};
				q_q   <= {q_q[XLEN-2:0], 1'b0};
			end else begin
				rem_q <= trial[XLEN-1:0];
				q_q   <= {q_q[XLEN-2:0], 1'b1};
			end
		end
	end

	assign done = done_q;
	assign quot = neg_q ? (XLEN'(0) - q_q) : q_q;

endmodule

FILE: src/rpn_stack_evaluator.sv
// push, invalid, end and any token while an error is latched: result registered as the token is taken
// add, subtract, multiply: stack memory read, execute, write back
// divide: stack memory read, then the bit-per-cycle restoring divider (32 iterations), then write back
// one token in flight at a time; the next one is taken once the result is registered and the output is free
// reset (arst_n low, asynchronous) empties the stack, clears the error and the output valid
module rpn_stack_evaluator #(
	parameter int unsigned STACK_DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [2:0]               kind,
	input  logic signed [31:0]       operand,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [2:0]               status,
	output logic signed [31:0]       top_value,
	output logic                     expr_done
);
	import rpn_pkg::*;

	localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AW = $clog2(STACK_DEPTH);

	state_t          state_q, state_d;
	logic [DW-1:0]   depth_q, depth_d;
	status_t         err_q, err_d;
	logic [XLEN-1:0] top_q, top_d;
	logic [XLEN-1:0] res_q, res_d;
	kind_t           op_q, op_d;

	logic            out_valid_q;
	status_t         out_status_q;
	logic [XLEN-1:0] out_top_q;
	logic            out_done_q;

	logic            out_free;
	logic            accept;
	logic            out_load;
	status_t         ld_status;
	logic [XLEN-1:0] ld_top;
	logic            ld_done;

	logic            ram_we;
	logic            ram_re;
	logic [AW-1:0]   ram_waddr;
	logic [AW-1:0]   ram_raddr;
	logic [XLEN-1:0] ram_rdata;
	logic [DW-1:0]   depth_m1;
	logic [DW-1:0]   depth_m2;
	logic [XLEN-1:0] cur_top;
	logic [XLEN-1:0] prod;
	logic            div_start;
	logic            div_done;
	logic [XLEN-1:0] div_quot;

	// top of stack lives in top_q; the memory holds the entries below it
	assign depth_m1  = depth_q - DW'(1);
	assign depth_m2  = depth_q - DW'(2);
	assign ram_waddr = depth_m1[AW-1:0];
	assign ram_raddr = depth_m2[AW-1:0];
	assign cur_top   = (depth_q == '0) ? '0 : top_q;
	assign prod      = ram_rdata * top_q;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;

	rpn_ram #(
		.WIDTH (XLEN),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (top_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rpn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (ram_rdata),
		.den    (top_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		state_d   = state_q;
		depth_d   = depth_q;
		err_d     = err_q;
		top_d     = top_q;
		res_d     = res_q;
		op_d      = op_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		ld_status = err_q;
		ld_top    = cur_top;
		ld_done   = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					out_load = 1'b1;
					if (kind_t'(kind) == KIND_END) begin
						ld_done = 1'b1;
						ld_top  = '0;
						if (err_q != STAT_OK) begin
							ld_status = err_q;
						end else if (depth_q != DW'(1)) begin
							ld_status = STAT_DEPTH;
						end else begin
							ld_status = STAT_OK;
							ld_top    = top_q;
						end
						depth_d = '0;
						err_d   = STAT_OK;
					end else if (err_q != STAT_OK) begin
						// latched error: token dropped, report error again
						ld_status = err_q;
					end else begin
						case (kind_t'(kind))
							KIND_PUSH: begin
								if (depth_q == DW'(STACK_DEPTH)) begin
									err_d     = STAT_OVERFLOW;
									ld_status = STAT_OVERFLOW;
								end else begin
									ram_we    = (depth_q != '0);
									top_d     = operand;
									depth_d   = depth_q + DW'(1);
									ld_status = STAT_OK;
									ld_top    = operand;
								end
							end
							KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
								if (depth_q < DW'(2)) begin
									err_d     = STAT_FEW;
									ld_status = STAT_FEW;
								end else if (kind_t'(kind) == KIND_DIV && top_q == '0) begin
									err_d     = STAT_DIVZERO;
									ld_status = STAT_DIVZERO;
								end else begin
									// result comes later from ST_FIN
									out_load = 1'b0;
									ram_re   = 1'b1;
									op_d     = kind_t'(kind);
									state_d  = ST_READ;
								end
							end
							default: begin
								err_d     = STAT_INVALID;
								ld_status = STAT_INVALID;
							end
						endcase
					end
				end
			end
			ST_READ: begin
				// second operand is on the memory read port now
				case (op_q)
					KIND_ADD: begin
						res_d   = ram_rdata + top_q;
						state_d = ST_FIN;
					end
					KIND_SUB: begin
						res_d   = ram_rdata - top_q;
						state_d = ST_FIN;
					end
					KIND_MUL: begin
						res_d   = prod;
						state_d = ST_FIN;
					end
					default: begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				endcase
			end
			ST_DIV: begin
				if (div_done) begin
					res_d   = div_quot;
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_load  = 1'b1;
					ld_status = STAT_OK;
					ld_top    = res_q;
					top_d     = res_q;
					depth_d   = depth_m1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			depth_q     <= '0;
			err_q       <= STAT_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			err_q   <= err_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_d;
		res_q <= res_d;
		op_q  <= op_d;
		if (out_load) begin
			out_status_q <= ld_status;
			out_top_q    <= ld_top;
			out_done_q   <= ld_done;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign top_value = out_top_q;
	assign expr_done = out_done_q;

endmodule

FILE: src/rpn_checker.sv
module rpn_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [2:0]         kind,
	input  logic signed [31:0] operand,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [2:0]         status,
	input  logic signed [31:0] top_value,
	input  logic               expr_done
);
	import rpn_pkg::*;

	// stalled input transaction keeps its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(kind) && $stable(operand))
		else $error("input changed while stalled");

	// stalled result transaction keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(top_value) && $stable(expr_done))
		else $error("result changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= STAT_OVERFLOW)
		else $error("status code out of range");

	a_end_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expr_done && status != STAT_OK |-> top_value == '0)
		else $error("failed expression reports nonzero value");

	a_depth_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_DEPTH |-> expr_done)
		else $error("bad final depth reported before end token");

endmodule

bind rpn_stack_evaluator rpn_checker u_rpn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.kind      (kind),
	.operand   (operand),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.top_value (top_value),
	.expr_done (expr_done)
);

FILE: tb/rpn_stack_evaluator_tb.sv
`timescale 1ns / 1ps

module rpn_stack_evaluator_tb;
	import rpn_pkg::*;

	localparam int unsigned STACK_DEPTH = 32;
	localparam logic [2:0] KIND_UNUSED = 3'd7;
	localparam int TOTAL_TOKENS = 545;
	localparam int DRAIN_CYCLES = 60;
	localparam int LONG_HOLD = 250;
	localparam int MAX_PRINTS = 100;

	typedef struct {
		logic [2:0]  kind;
		logic [31:0] operand;
	} token_t;

	typedef struct {
		status_t     status;
		logic [31:0] top;
		logic        done;
	} stack_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         kind = 3'd0;
	logic signed [31:0] operand = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         status;
	logic signed [31:0] top_value;
	logic               expr_done;

	logic hold_off = 1'b0;
	int   tokens_taken = 0;
	int   results_seen = 0;
	int   mismatches = 0;

	token_t        pending_tokens[$];
	stack_result_t awaited_results[$];
	stack_result_t head_result;

	// shadow copy of the evaluator state
	logic [31:0] stack_mem [STACK_DEPTH];
	int          stack_level = 0;
	status_t     latched_err = STAT_OK;

	rpn_stack_evaluator #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.operand(operand),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.top_value(top_value),
		.expr_done(expr_done)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic stack_result_t evaluate_token(input logic [2:0] k, input logic [31:0] v);
		stack_result_t res;
		logic [31:0]   tos;
		logic [31:0]   nos;
		logic [31:0]   val;
		logic [31:0]   nmag;
		logic [31:0]   dmag;
		logic [31:0]   quot;
		res.done = 1'b0;
		if (k == KIND_END) begin
			res.status = latched_err;
			res.top = '0;
			res.done = 1'b1;
			if (latched_err == STAT_OK) begin
				if (stack_level != 1)
					res.status = STAT_DEPTH;
				else
					res.top = stack_mem[0];
			end
			stack_level = 0;
			latched_err = STAT_OK;
			return res;
		end
		if (latched_err == STAT_OK) begin
			if (k == KIND_PUSH) begin
				if (stack_level >= STACK_DEPTH) begin
					latched_err = STAT_OVERFLOW;
				end else begin
					stack_mem[stack_level] = v;
					stack_level++;
				end
			end else if (k == KIND_ADD || k == KIND_SUB || k == KIND_MUL || k == KIND_DIV) begin
				if (stack_level < 2) begin
					latched_err = STAT_FEW;
				end else begin
					tos = stack_mem[stack_level - 1];
					nos = stack_mem[stack_level - 2];
					val = '0;
					if (k == KIND_ADD) begin
						val = nos + tos;
					end else if (k == KIND_SUB) begin
						val = nos - tos;
					end else if (k == KIND_MUL) begin
						val = nos * tos;
					end else if (tos == '0) begin
						latched_err = STAT_DIVZERO;
					end else begin
						// magnitudes keep min / -1 well defined
						nmag = nos[31] ? -nos : nos;
						dmag = tos[31] ? -tos : tos;
						quot = nmag / dmag;
						val = (nos[31] ^ tos[31]) ? -quot : quot;
					end
					if (latched_err == STAT_OK) begin
						stack_level--;
						stack_mem[stack_level - 1] = val;
					end
				end
			end else begin
				latched_err = STAT_INVALID;
			end
		end
		res.status = latched_err;
		res.top = (stack_level == 0) ? '0 : stack_mem[stack_level - 1];
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("%0t: mismatch on result %0d: %s", $time, results_seen, what);
	endtask

	function automatic void emit(input logic [2:0] k, input logic [31:0] v);
		token_t t;
		t.kind = k;
		t.operand = v;
		pending_tokens.push_back(t);
	endfunction

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom_range(40) - 20;
			4: return '0;
			5: begin
				case ($urandom_range(3))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'hffff_ffff;
					default: return 32'd1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_operator();
		return 3'($urandom_range(4, 1));
	endfunction

	// random well-formed expression, optionally with stray tokens mixed in
	function automatic void queue_expression(input int max_len, input bit mangle);
		int level;
		int len;
		level = 0;
		len = $urandom_range(max_len, 1);
		for (int i = 0; i < len; i++) begin
			if (mangle && $urandom_range(99) < 15)
				emit(3'($urandom_range(7)), pick_operand());
			if (level < 2 || (level < STACK_DEPTH && $urandom_range(99) < 50)) begin
				emit(KIND_PUSH, pick_operand());
				level++;
			end else begin
				emit(pick_operator(), pick_operand());
				level--;
			end
		end
		while (level > 1) begin
			emit(pick_operator(), pick_operand());
			level--;
		end
		emit(KIND_END, pick_operand());
	endfunction

	// fill the stack completely, then either overflow it or fold it down
	function automatic void queue_full_stack(input bit overflow);
		for (int i = 0; i < STACK_DEPTH; i++)
			emit(KIND_PUSH, pick_operand());
		if (overflow) begin
			emit(KIND_PUSH, pick_operand());
		end else begin
			for (int i = 1; i < STACK_DEPTH; i++)
				emit(pick_operator(), pick_operand());
		end
		emit(KIND_END, '0);
	endfunction

	initial begin
		int pick;
		// wraparound on add
		emit(KIND_PUSH, 32'h7fff_ffff);
		emit(KIND_PUSH, 32'd1);
		emit(KIND_ADD, 32'hffff_ffff);
		emit(KIND_END, '0);
		// most negative divided by minus one
		emit(KIND_PUSH, 32'h8000_0000);
		emit(KIND_PUSH, 32'hffff_ffff);
		emit(KIND_DIV, '0);
		emit(KIND_END, '0);
		// truncating divide, subtract, multiply
		emit(KIND_PUSH, -32'sd7);
		emit(KIND_PUSH, 32'd2);
		emit(KIND_DIV, '0);
		emit(KIND_PUSH, 32'd3);
		emit(KIND_SUB, '0);
		emit(KIND_PUSH, 32'hffff_ffff);
		emit(KIND_MUL, '0);
		emit(KIND_END, '0);
		// too few operands, then a push that the latched error swallows
		emit(KIND_ADD, '0);
		emit(KIND_PUSH, 32'd5);
		emit(KIND_END, '0);
		// zero divisor
		emit(KIND_PUSH, 32'd1);
		emit(KIND_PUSH, '0);
		emit(KIND_DIV, '0);
		emit(KIND_END, '0);
		// unused kind acts as an invalid token
		emit(KIND_UNUSED, 32'h5555_aaaa);
		emit(KIND_END, '0);
		// end on an empty stack
		emit(KIND_END, '0);

		while (pending_tokens.size() < TOTAL_TOKENS) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				queue_expression(12, 1'b0);
			end else if (pick < 88) begin
				queue_expression(10, 1'b1);
			end else if (pick < 92) begin
				queue_full_stack($urandom_range(1));
			end else begin
				repeat ($urandom_range(4, 1))
					emit(3'($urandom_range(7)), pick_operand());
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_tokens.size() != 0 || in_valid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("rpn_stack_evaluator_tb OK");
		else
			$display("rpn_stack_evaluator_tb NOT OK");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("rpn_stack_evaluator_tb NOT OK");
		$finish;
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		while (results_seen < 300)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		int gap_pct;
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= 3'd0;
			operand <= '0;
		end else begin
			gap_pct = (tokens_taken < 190) ? 33 : (tokens_taken < 380) ? 56 : 0;
			if (in_valid && !in_stall) begin
				awaited_results.push_back(evaluate_token(kind, operand));
				void'(pending_tokens.pop_front());
				tokens_taken <= tokens_taken + 1;
			end
			if (!in_valid || !in_stall) begin
				if (pending_tokens.size() != 0 && $urandom_range(99) >= gap_pct) begin
					in_valid <= 1'b1;
					kind <= pending_tokens[0].kind;
					operand <= pending_tokens[0].operand;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		int stall_pct;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			stall_pct = (results_seen < 190) ? 56 : (results_seen < 380) ? 33 : 0;
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("unexpected transaction, status %0d top %0d",
						status, top_value));
				end else begin
					head_result = awaited_results.pop_front();
					if (status !== head_result.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							status, head_result.status));
					if (top_value !== head_result.top)
						report_mismatch($sformatf("top_value %h, expected %h",
							top_value, head_result.top));
					if (expr_done !== head_result.done)
						report_mismatch($sformatf("expr_done %b, expected %b",
							expr_done, head_result.done));
				end
			end
			out_stall <= hold_off || ($urandom_range(99) < stall_pct);
		end
	end

endmodule
